/* rtl/olkd_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Ordered list package
// Shared widths, command and status codes, and sequencer states.
// ----------------------------------------------------------------------------
package olkd_pkg;

  localparam int CAPACITY_DEF = 32;
  localparam int CMD_W        = 3;
  localparam int VALUE_W      = 32;
  localparam int STATUS_W     = 3;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT    = 3'd0,
    CMD_DEL_KEY   = 3'd1,
    CMD_DEL_FIRST = 3'd2,
    CMD_DEL_LAST  = 3'd3,
    CMD_READ_OUT  = 3'd4
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE   = 3'd0,
    ST_FULL   = 3'd1,
    ST_EMPTY  = 3'd2,
    ST_NOKEY  = 3'd3,
    ST_LISTED = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_LIST,
    S_FIN
  } state_e;

endpackage
`default_nettype wire

/* rtl/olkd_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module olkd_ram #(
  parameter int DATA_W = 32,
  parameter int DEPTH  = 32,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [DATA_W-1:0] wdata_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output      logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule
`default_nettype wire

/* rtl/ordered_list_with_key_delete.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Ordered list with key delete
// Holds up to CAPACITY signed values head first in a circular buffer RAM.
//
//   Channel  Direction  Signals
//   in       sink       in_valid_i, in_ready_o, cmd_i, value_i
//   out      source     out_valid_o, out_ready_i, item_value_o, status_o,
//                       is_last_o, entry_count_o
//
// Insert, delete-first, delete-last and rejected commands are handled in the idle state.
// Delete-key scans the entries up to the match, then makes one RAM move per entry
// behind it, as the single RAM port pair allows.
// Read-out sends one entry per cycle while the output is taken.
// After reset the list is empty; no clearing pass is needed.
// A stalled output holds the sequencer; one command waits in the input register.
// ----------------------------------------------------------------------------
module ordered_list_with_key_delete #(
  parameter int CAPACITY = olkd_pkg::CAPACITY_DEF,
  localparam int CW = $clog2(CAPACITY + 1)
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  output      logic                                in_ready_o,
  input  wire logic [olkd_pkg::CMD_W-1:0]          cmd_i,
  input  wire logic signed [olkd_pkg::VALUE_W-1:0] value_i,
  output      logic                                out_valid_o,
  input  wire logic                                out_ready_i,
  output      logic signed [olkd_pkg::VALUE_W-1:0] item_value_o,
  output      logic [olkd_pkg::STATUS_W-1:0]       status_o,
  output      logic                                is_last_o,
  output      logic [CW-1:0]                       entry_count_o
);

  import olkd_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam logic [AW:0]   CAP_X    = (AW + 1)'(CAPACITY);
  localparam logic [AW-1:0] LAST_IDX = AW'(CAPACITY - 1);
  localparam logic [CW-1:0] CAP_C    = CW'(CAPACITY);

  function automatic logic [AW-1:0] wrap_add(logic [AW-1:0] a, logic [AW-1:0] b);
    logic [AW:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= CAP_X) begin
      s = s - CAP_X;
    end
    return s[AW-1:0];
  endfunction

  state_e                     state_q, state_d;
  logic                       cmd_vld_q, cmd_vld_d;
  logic [CMD_W-1:0]           cmd_q;
  logic signed [VALUE_W-1:0]  val_q;
  logic [AW-1:0]              head_q, head_d;
  logic [CW-1:0]              cnt_q, cnt_d;
  logic [AW-1:0]              idx_q, idx_d;
  status_e                    stat_q, stat_d;

  logic                       out_vld_q;
  logic signed [VALUE_W-1:0]  out_val_q, out_val_d;
  status_e                    out_stat_q, out_stat_d;
  logic                       out_last_q, out_last_d;
  logic [CW-1:0]              out_cnt_q, out_cnt_d;
  logic                       out_load, out_free;

  logic                       ram_we;
  logic [AW-1:0]              ram_waddr, ram_raddr;
  logic [VALUE_W-1:0]         ram_wdata, ram_rdata;

  logic [CW-1:0]              idx_x;
  logic                       in_xfer;

  assign in_ready_o = !cmd_vld_q;
  assign in_xfer    = in_valid_i && in_ready_o;
  assign out_free   = !out_vld_q || out_ready_i;
  assign idx_x      = CW'(idx_q);

  olkd_ram #(
    .DATA_W (VALUE_W),
    .DEPTH  (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d    = state_q;
    cmd_vld_d  = cmd_vld_q;
    head_d     = head_q;
    cnt_d      = cnt_q;
    idx_d      = idx_q;
    stat_d     = stat_q;
    out_load   = 1'b0;
    out_val_d  = '0;
    out_stat_d = ST_DONE;
    out_last_d = 1'b1;
    out_cnt_d  = cnt_q;
    ram_we     = 1'b0;
    ram_waddr  = head_q;
    ram_wdata  = val_q;
    ram_raddr  = head_q;

    if (in_xfer) begin
      cmd_vld_d = 1'b1;
    end

    unique case (state_q)
      S_IDLE: begin
        ram_raddr = head_q;
        idx_d     = '0;
        if (cmd_vld_q) begin
          unique case (cmd_q)
            CMD_INSERT: begin
              if (out_free) begin
                if (cnt_q == CAP_C) begin
                  out_stat_d = ST_FULL;
                end else begin
                  head_d    = (head_q == '0) ? LAST_IDX : head_q - AW'(1);
                  ram_we    = 1'b1;
                  ram_waddr = head_d;
                  cnt_d     = cnt_q + CW'(1);
                end
                out_load  = 1'b1;
                out_cnt_d = cnt_d;
                cmd_vld_d = 1'b0;
              end
            end
            CMD_DEL_FIRST, CMD_DEL_LAST: begin
              if (out_free) begin
                if (cnt_q == '0) begin
                  out_stat_d = ST_EMPTY;
                end else begin
                  cnt_d = cnt_q - CW'(1);
                  if (cmd_q == CMD_DEL_FIRST) begin
                    head_d = wrap_add(head_q, AW'(1));
                  end
                end
                out_load  = 1'b1;
                out_cnt_d = cnt_d;
                cmd_vld_d = 1'b0;
              end
            end
            CMD_DEL_KEY: begin
              if (cnt_q == '0) begin
                if (out_free) begin
                  out_stat_d = ST_NOKEY;
                  out_load   = 1'b1;
                  cmd_vld_d  = 1'b0;
                end
              end else begin
                state_d = S_SCAN;
              end
            end
            CMD_READ_OUT: begin
              if (cnt_q == '0) begin
                if (out_free) begin
                  out_stat_d = ST_EMPTY;
                  out_load   = 1'b1;
                  cmd_vld_d  = 1'b0;
                end
              end else begin
                state_d = S_LIST;
              end
            end
            default: begin
              if (out_free) begin
                out_load  = 1'b1;
                cmd_vld_d = 1'b0;
              end
            end
          endcase
        end
      end
      S_SCAN: begin
        ram_raddr = wrap_add(head_q, idx_q + AW'(1));
        if (ram_rdata == val_q) begin
          if (idx_x + CW'(1) == cnt_q) begin
            cnt_d   = cnt_q - CW'(1);
            stat_d  = ST_DONE;
            state_d = S_FIN;
          end else begin
            state_d = S_SHIFT;
          end
        end else if (idx_x + CW'(1) == cnt_q) begin
          stat_d  = ST_NOKEY;
          state_d = S_FIN;
        end else begin
          idx_d = idx_q + AW'(1);
        end
      end
      S_SHIFT: begin
        ram_we    = 1'b1;
        ram_waddr = wrap_add(head_q, idx_q);
        ram_wdata = ram_rdata;
        ram_raddr = wrap_add(head_q, idx_q + AW'(2));
        if (idx_x + CW'(2) >= cnt_q) begin
          cnt_d   = cnt_q - CW'(1);
          stat_d  = ST_DONE;
          state_d = S_FIN;
        end else begin
          idx_d = idx_q + AW'(1);
        end
      end
      S_LIST: begin
        if (out_free) begin
          ram_raddr  = wrap_add(head_q, idx_q + AW'(1));
          out_load   = 1'b1;
          out_val_d  = ram_rdata;
          out_stat_d = ST_LISTED;
          out_last_d = (idx_x + CW'(1) == cnt_q);
          if (out_last_d) begin
            cmd_vld_d = 1'b0;
            state_d   = S_IDLE;
          end else begin
            idx_d = idx_q + AW'(1);
          end
        end else begin
          ram_raddr = wrap_add(head_q, idx_q);
        end
      end
      S_FIN: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_stat_d = stat_q;
          cmd_vld_d  = 1'b0;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cmd_vld_q <= 1'b0;
      head_q    <= '0;
      cnt_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cmd_vld_q <= cmd_vld_d;
      head_q    <= head_d;
      cnt_q     <= cnt_d;
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      cmd_q <= cmd_i;
      val_q <= value_i;
    end
    idx_q  <= idx_d;
    stat_q <= stat_d;
    if (out_load) begin
      out_val_q  <= out_val_d;
      out_stat_q <= out_stat_d;
      out_last_q <= out_last_d;
      out_cnt_q  <= out_cnt_d;
    end
  end

  assign out_valid_o   = out_vld_q;
  assign item_value_o  = out_val_q;
  assign status_o      = out_stat_q;
  assign is_last_o     = out_last_q;
  assign entry_count_o = out_cnt_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CAP_C)
    else $error("Entry count exceeds capacity.");

  a_idle_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cmd_vld_q |-> state_q == S_IDLE)
    else $error("Sequencer busy without a pending command.");

  a_partial_in_list: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !out_last_q) |-> (state_q == S_LIST && cmd_vld_q))
    else $error("Non-final result outside of read-out.");

  a_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(cnt_q) |-> (cnt_q == $past(cnt_q) + CW'(1)) ||
                        (cnt_q + CW'(1) == $past(cnt_q)))
    else $error("Entry count moved by more than one.");

endmodule
`default_nettype wire

/* test/tb_ordered_list_with_key_delete.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Ordered list with key delete testbench
// Sends list commands through the input channel and compares every result
// with a queue-based model of the list that is updated at each accepted
// transfer. A short directed part covers the empty and full corners, the
// extreme values and the unused command codes. Bursts of random commands
// then grow, shrink and list the contents. Both channels stall at random,
// with one stretch in the middle that runs at full rate.
// ----------------------------------------------------------------------------
module tb_ordered_list_with_key_delete;
  import olkd_pkg::*;

  localparam int CAP = CAPACITY_DEF;
  localparam int CNT_W = $clog2(CAP + 1);
  localparam int TOTAL_ITEMS = 250;
  localparam logic [CMD_W-1:0] CMD_RSVD_LO = 3'd5;
  localparam logic [CMD_W-1:0] CMD_RSVD_HI = 3'd7;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic signed [VALUE_W-1:0] value;
  } list_cmd_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] item_value;
    status_e status;
    logic is_last;
    logic [CNT_W-1:0] entry_count;
  } list_result_t;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_ready_o;
  logic [CMD_W-1:0] cmd_i;
  logic signed [VALUE_W-1:0] value_i;
  logic out_valid_o;
  logic out_ready_i;
  logic signed [VALUE_W-1:0] item_value_o;
  logic [STATUS_W-1:0] status_o;
  logic is_last_o;
  logic [CNT_W-1:0] entry_count_o;

  list_cmd_t cmds_to_send[$];
  logic signed [VALUE_W-1:0] planned_list[$];
  logic signed [VALUE_W-1:0] model_list[$];
  list_result_t due_results[$];

  bit in_taken;
  int accepted_n;
  int checked_n;
  int err_n;
  int max_fill;
  int cmd_n[8];
  int status_n[8];

  ordered_list_with_key_delete #(
    .CAPACITY(CAP)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .cmd_i        (cmd_i),
    .value_i      (value_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .item_value_o (item_value_o),
    .status_o     (status_o),
    .is_last_o    (is_last_o),
    .entry_count_o(entry_count_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  task automatic plan_cmd(input logic [CMD_W-1:0] cmd, input logic signed [VALUE_W-1:0] value);
    int hit;
    hit = -1;
    cmds_to_send.push_back('{cmd: cmd, value: value});
    case (cmd)
      CMD_INSERT: if (planned_list.size() < CAP) planned_list.push_front(value);
      CMD_DEL_KEY: begin
        foreach (planned_list[i]) if (hit < 0 && planned_list[i] == value) hit = i;
        if (hit >= 0) planned_list.delete(hit);
      end
      CMD_DEL_FIRST: if (planned_list.size() > 0) planned_list.delete(0);
      CMD_DEL_LAST: if (planned_list.size() > 0) planned_list.delete(planned_list.size() - 1);
      default: ;
    endcase
  endtask

  function automatic logic signed [VALUE_W-1:0] pick_value();
    case ($urandom_range(3))
      0: return $urandom_range(7) - 4;
      1: begin
        case ($urandom_range(3))
          0: return 32'sh7FFF_FFFF;
          1: return 32'sh8000_0000;
          2: return 32'sd0;
          default: return -32'sd1;
        endcase
      end
      default: return $urandom();
    endcase
  endfunction

  function automatic logic signed [VALUE_W-1:0] pick_key();
    if (planned_list.size() > 0 && $urandom_range(99) < 75) begin
      return planned_list[$urandom_range(planned_list.size() - 1)];
    end
    return pick_value();
  endfunction

  task automatic apply_list_command(input list_cmd_t c);
    int hit;
    status_e st;
    bit listed;
    hit = -1;
    st = ST_DONE;
    listed = 1'b0;
    case (c.cmd)
      CMD_INSERT: begin
        if (model_list.size() >= CAP) st = ST_FULL;
        else model_list.push_front(c.value);
      end
      CMD_DEL_KEY: begin
        st = ST_NOKEY;
        foreach (model_list[i]) if (hit < 0 && model_list[i] == c.value) hit = i;
        if (hit >= 0) begin
          model_list.delete(hit);
          st = ST_DONE;
        end
      end
      CMD_DEL_FIRST: begin
        if (model_list.size() == 0) st = ST_EMPTY;
        else model_list.delete(0);
      end
      CMD_DEL_LAST: begin
        if (model_list.size() == 0) st = ST_EMPTY;
        else model_list.delete(model_list.size() - 1);
      end
      CMD_READ_OUT: begin
        if (model_list.size() == 0) begin
          st = ST_EMPTY;
        end else begin
          listed = 1'b1;
          foreach (model_list[i]) begin
            due_results.push_back('{item_value: model_list[i], status: ST_LISTED,
                                   is_last: (i == model_list.size() - 1),
                                   entry_count: CNT_W'(model_list.size())});
          end
        end
      end
      default: ;
    endcase
    if (!listed) begin
      due_results.push_back('{item_value: '0, status: st, is_last: 1'b1,
                             entry_count: CNT_W'(model_list.size())});
    end
    if (model_list.size() > max_fill) max_fill = model_list.size();
  endtask

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      err_n++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  always @(negedge clk_i) begin
    list_cmd_t nxt;
    bit quiet;
    quiet = (accepted_n >= 100) && (accepted_n < 170);
    if (rst_ni) begin
      if (!in_valid_i || in_taken) begin
        if (cmds_to_send.size() > 0 && (quiet || $urandom_range(99) >= 37)) begin
          nxt = cmds_to_send[0];
          cmds_to_send.delete(0);
          in_valid_i <= 1'b1;
          cmd_i <= nxt.cmd;
          value_i <= nxt.value;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      out_ready_i <= quiet || ($urandom_range(99) >= 37);
    end
  end

  always @(posedge clk_i) begin
    list_result_t want;
    in_taken <= rst_ni && in_valid_i && in_ready_o;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        apply_list_command('{cmd: cmd_i, value: value_i});
        cmd_n[cmd_i]++;
        accepted_n++;
      end
      if (out_valid_o && out_ready_i) begin
        checked_n++;
        status_n[status_o]++;
        if (due_results.size() == 0) begin
          err_n++;
          $display("%0t: result with nothing expected, actual value %0d status %0d",
                   $time, item_value_o, status_o);
        end else begin
          want = due_results[0];
          due_results.delete(0);
          check_field("item_value", want.item_value, item_value_o);
          check_field("status", want.status, status_o);
          check_field("is_last", want.is_last, is_last_o);
          check_field("entry_count", want.entry_count, entry_count_o);
        end
      end
    end
  end

  initial begin
    int mode;
    int r;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    cmd_i = CMD_INSERT;
    value_i = '0;
    out_ready_i = 1'b0;
    in_taken = 1'b0;

    plan_cmd(CMD_READ_OUT, 32'sd0);
    plan_cmd(CMD_DEL_FIRST, 32'sd0);
    plan_cmd(CMD_DEL_LAST, 32'sd0);
    plan_cmd(CMD_DEL_KEY, 32'sd0);
    for (int c = CMD_RSVD_LO; c <= CMD_RSVD_HI; c++) plan_cmd(CMD_W'(c), -32'sd1);
    plan_cmd(CMD_INSERT, 32'sh7FFF_FFFF);
    plan_cmd(CMD_INSERT, 32'sh8000_0000);
    plan_cmd(CMD_INSERT, 32'sd0);
    plan_cmd(CMD_INSERT, -32'sd1);
    plan_cmd(CMD_INSERT, 32'sd0);
    plan_cmd(CMD_READ_OUT, 32'sd0);
    plan_cmd(CMD_DEL_KEY, 32'sd0);
    plan_cmd(CMD_DEL_KEY, 32'sd12345);
    plan_cmd(CMD_DEL_KEY, 32'sh8000_0000);
    plan_cmd(CMD_READ_OUT, 32'sd0);
    plan_cmd(CMD_DEL_FIRST, 32'sd0);
    plan_cmd(CMD_DEL_LAST, 32'sd0);
    plan_cmd(CMD_READ_OUT, 32'sd0);
    plan_cmd(CMD_DEL_KEY, 32'sd0);
    plan_cmd(CMD_INSERT, 32'sd5);
    plan_cmd(CMD_DEL_LAST, 32'sd0);

    // Fill the list to the top, then push past it once it is full.
    while (planned_list.size() < CAP) plan_cmd(CMD_INSERT, pick_value());
    plan_cmd(CMD_INSERT, pick_value());
    plan_cmd(CMD_INSERT, pick_value());
    plan_cmd(CMD_READ_OUT, pick_value());
    plan_cmd(CMD_DEL_KEY, pick_key());
    plan_cmd(CMD_DEL_KEY, pick_key());

    while (cmds_to_send.size() < TOTAL_ITEMS) begin
      mode = $urandom_range(2);
      repeat ($urandom_range(8, 24)) begin
        r = $urandom_range(99);
        case (mode)
          0: begin
            if (r < 70) plan_cmd(CMD_INSERT, pick_value());
            else if (r < 80) plan_cmd(CMD_DEL_KEY, pick_key());
            else if (r < 90) plan_cmd(CMD_READ_OUT, pick_value());
            else if (r < 95) plan_cmd(CMD_DEL_FIRST, pick_value());
            else plan_cmd(CMD_DEL_LAST, pick_value());
          end
          1: begin
            if (r < 35) plan_cmd(CMD_DEL_KEY, pick_key());
            else if (r < 55) plan_cmd(CMD_DEL_FIRST, pick_value());
            else if (r < 75) plan_cmd(CMD_DEL_LAST, pick_value());
            else if (r < 85) plan_cmd(CMD_DEL_KEY, pick_value());
            else plan_cmd(CMD_READ_OUT, pick_value());
          end
          default: begin
            if (r < 30) plan_cmd(CMD_INSERT, pick_value());
            else if (r < 50) plan_cmd(CMD_DEL_KEY, pick_key());
            else if (r < 62) plan_cmd(CMD_DEL_FIRST, pick_value());
            else if (r < 74) plan_cmd(CMD_DEL_LAST, pick_value());
            else if (r < 94) plan_cmd(CMD_READ_OUT, pick_value());
            else plan_cmd(CMD_W'($urandom_range(CMD_RSVD_LO, CMD_RSVD_HI)), pick_value());
          end
        endcase
      end
    end

    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;

    while (cmds_to_send.size() != 0 || in_valid_i || due_results.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (2 * CAP + 10) @(posedge clk_i);

    $display("Sent %0d commands: %0d inserts, %0d key deletes, %0d head and %0d tail deletes,",
             accepted_n, cmd_n[CMD_INSERT], cmd_n[CMD_DEL_KEY], cmd_n[CMD_DEL_FIRST],
             cmd_n[CMD_DEL_LAST]);
    $display("%0d read-outs; %0d results checked, %0d full, %0d empty, %0d missing keys, peak %0d.",
             cmd_n[CMD_READ_OUT], checked_n, status_n[ST_FULL], status_n[ST_EMPTY],
             status_n[ST_NOKEY], max_fill);
    if (err_n == 0) begin
      $display("ordered_list_with_key_delete regression: pass");
    end else begin
      $display("ordered_list_with_key_delete regression: fail");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("ordered_list_with_key_delete regression: fail");
    $finish;
  end

endmodule

/* filelist.f */
rtl/olkd_pkg.sv
rtl/olkd_ram.sv
rtl/ordered_list_with_key_delete.sv
test/tb_ordered_list_with_key_delete.sv
